// File: design/ising_pkg.sv
// Shared constants, types and the sequencer state type for the Ising spin-update block.
// Depends on nothing; imported by ising_metropolis_spin_update.
package ising_pkg;

    localparam int SIDE      = 64;
    localparam int ROW_W     = $clog2(SIDE);
    localparam int SITES     = SIDE * SIDE;
    localparam int PROB_BITS = 16;
    localparam int PROB_W    = PROB_BITS + 1;
    localparam int DE_W      = 5;
    localparam int ENERGY_W  = 15;
    localparam int MAG_W     = 14;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [PROB_W-1:0]          PROB_ONE     = PROB_W'(1) << PROB_BITS;
    localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITES);
    localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITES);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_DELTA4 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_DELTA8 = CFG_IDX_W'(1);

    // Item kinds.
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_ATTEMPT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_MID,
        S_RD_DN,
        S_NB,
        S_EVAL
    } t_state;

endpackage

// File: design/ising_metropolis_spin_update.sv
// Metropolis single-site update of a 2D periodic Ising lattice held as a row memory.
// Depends on ising_pkg (constants, state type).
//
//  channel   direction  handshake                   payload
//  --------  ---------  --------------------------  -------------------------------------------
//  input     in         i_valid / o_ready           action, row, col, spin_value, random_fraction
//  result    out        o_valid / i_ready           flipped, delta_energy, energy,
//                                                   magnetization, accepted_count, spin_now
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// For each item the single read port of the row memory fetches rows r-1, r and r+1 one
// after another, then the evaluate state decides and writes row r back.
// After reset a clearing pass writes all 64 rows to +1; no item is taken then,
// configuration writes are taken at any time.
// A finished result waits in the output register; the next item is accepted meanwhile and
// stalls only in its evaluate state until the output register frees up.
module ising_metropolis_spin_update
    import ising_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [ROW_W-1:0]           i_row,
    input  logic [ROW_W-1:0]           i_col,
    input  logic                       i_spin_value,
    input  logic [PROB_BITS-1:0]       i_random_fraction,

    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_flipped,
    output logic signed [DE_W-1:0]     o_delta_energy,
    output logic signed [ENERGY_W-1:0] o_energy,
    output logic signed [MAG_W-1:0]    o_magnetization,
    output logic [COUNT_W-1:0]         o_accepted_count,
    output logic                       o_spin_now,

    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [PROB_W-1:0]          i_cfg_data
);

    // Row memory: one word per lattice row, bit c is the spin at column c (1 means +1).
    logic [SIDE-1:0]           r_mem [SIDE];
    logic [SIDE-1:0]           r_rd_data;

    t_state                    r_state, n_state;
    logic [ROW_W-1:0]          r_clr_addr;

    logic                      r_action;
    logic [ROW_W-1:0]          r_row;
    logic [ROW_W-1:0]          r_col;
    logic                      r_spin_val;
    logic [PROB_BITS-1:0]      r_rnd;
    logic                      r_up;
    logic                      r_dn;
    logic [SIDE-1:0]           r_mid;

    logic [PROB_W-1:0]         r_prob4;
    logic [PROB_W-1:0]         r_prob8;
    logic signed [ENERGY_W-1:0] r_energy;
    logic signed [MAG_W-1:0]   r_mag;
    logic [COUNT_W-1:0]        r_count;

    logic                      r_out_valid;
    logic                      r_out_flipped;
    logic signed [DE_W-1:0]    r_out_de;
    logic                      r_out_spin;

    logic                      mem_we;
    logic [ROW_W-1:0]          mem_addr;
    logic [SIDE-1:0]           mem_wdata;
    logic                      commit;

    logic [ROW_W-1:0]          col_p, col_m;
    logic                      s_bit;
    logic [2:0]                n_ones;
    logic [2:0]                k_same;
    logic signed [DE_W:0]      de_wide;
    logic signed [DE_W-1:0]    de;
    logic                      change;
    logic                      new_spin;

    // Energy change from the neighbor pattern: dE = 4*k - 8, k = neighbors equal to s.
    always_comb begin
        col_p    = ROW_W'(r_col + 1'b1);
        col_m    = ROW_W'(r_col - 1'b1);
        s_bit    = r_mid[r_col];
        n_ones   = 3'(r_mid[col_p]) + 3'(r_mid[col_m]) + 3'(r_up) + 3'(r_dn);
        k_same   = s_bit ? n_ones : 3'(3'd4 - n_ones);
        de_wide  = $signed({1'b0, k_same, 2'b00}) - (DE_W+1)'(8);
        de       = de_wide[DE_W-1:0];
        if (r_action == ACT_WRITE) begin
            change = (r_spin_val != s_bit);
        end else if (k_same <= 3'd2) begin
            change = 1'b1;
        end else if (k_same == 3'd3) begin
            change = (r_prob4 >= {1'b0, r_rnd});
        end else begin
            change = (r_prob8 >= {1'b0, r_rnd});
        end
        new_spin = s_bit ^ change;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_row;
        mem_wdata = r_mid;
        commit    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '1;
                if (r_clr_addr == ROW_W'(SIDE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready  = 1'b1;
                mem_addr = ROW_W'(i_row - 1'b1);
                if (i_valid) begin
                    n_state = S_RD_MID;
                end
            end
            S_RD_MID: begin
                mem_addr = r_row;
                n_state  = S_RD_DN;
            end
            S_RD_DN: begin
                mem_addr = ROW_W'(r_row + 1'b1);
                n_state  = S_NB;
            end
            S_NB: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_ready) begin
                    commit             = 1'b1;
                    mem_we             = 1'b1;
                    mem_addr           = r_row;
                    mem_wdata[r_col]   = new_spin;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_prob4     <= PROB_ONE;
            r_prob8     <= PROB_ONE;
            r_energy    <= ENERGY_RESET;
            r_mag       <= MAG_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= ROW_W'(r_clr_addr + 1'b1);
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PROB_DELTA4) begin
                    r_prob4 <= i_cfg_data;
                end else if (i_cfg_index == CFG_PROB_DELTA8) begin
                    r_prob8 <= i_cfg_data;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                if (change) begin
                    r_energy <= r_energy + ENERGY_W'(de);
                    r_mag    <= s_bit ? MAG_W'(r_mag - MAG_W'(2)) : MAG_W'(r_mag + MAG_W'(2));
                end
                if (change && r_action == ACT_ATTEMPT) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_action   <= i_action;
            r_row      <= i_row;
            r_col      <= i_col;
            r_spin_val <= i_spin_value;
            r_rnd      <= i_random_fraction;
        end
        if (r_state == S_RD_MID) begin
            r_up <= r_rd_data[r_col];
        end
        if (r_state == S_RD_DN) begin
            r_mid <= r_rd_data;
        end
        if (r_state == S_NB) begin
            r_dn <= r_rd_data[r_col];
        end
        if (commit) begin
            r_out_flipped <= change;
            r_out_de      <= change ? de : '0;
            r_out_spin    <= new_spin;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_flipped        = r_out_flipped;
    assign o_delta_energy   = r_out_de;
    assign o_energy         = r_energy;
    assign o_magnetization  = r_mag;
    assign o_accepted_count = r_count;
    assign o_spin_now       = r_out_spin;

endmodule
